// File: rtl/icc_pkg.sv
// Shared constants for the interlace comb check block.
// Field widths, register indexes, row codes and mask values; no dependencies.
`default_nettype none

package icc_pkg;

    localparam int SAMPLE_BITS_DEFAULT = 16;

    localparam int FIELD_W    = 16;
    localparam int ROW_W      = 3;
    localparam int THR_W      = 17;
    localparam int SIX_T_W    = 19;
    localparam int T_SQ_W     = 32;
    localparam int IN_DATA_W  = 104;   // 99 field bits, padded to 13 bytes
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    // Register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_METRIC_MODE = 1'b1;

    // Metric selection
    localparam logic METRIC_COMB    = 1'b0;
    localparam logic METRIC_PRODUCT = 1'b1;

    // Row position codes
    localparam logic [ROW_W-1:0] ROW_TOP      = 3'd0;
    localparam logic [ROW_W-1:0] ROW_SECOND   = 3'd1;
    localparam logic [ROW_W-1:0] ROW_INTERIOR = 3'd2;
    localparam logic [ROW_W-1:0] ROW_PENULT   = 3'd3;
    localparam logic [ROW_W-1:0] ROW_LAST     = 3'd4;

    // Mask values
    localparam logic [FIELD_W-1:0] MASK_MOVING  = 16'd60;
    localparam logic [FIELD_W-1:0] MASK_DEMOTED = 16'd10;

endpackage

`default_nettype wire

// File: rtl/icc_datapath.sv
// Combinational comb evaluation for one pixel: edge mirroring, neighbor
// differences, five-tap comb test and the difference product. Uses icc_pkg.
`default_nettype none

module icc_datapath #(
    parameter int SAMPLE_BITS = icc_pkg::SAMPLE_BITS_DEFAULT
) (
    input  wire logic [icc_pkg::ROW_W-1:0]     row_position,
    input  wire logic [SAMPLE_BITS-1:0]        above_two,
    input  wire logic [SAMPLE_BITS-1:0]        above_one,
    input  wire logic [SAMPLE_BITS-1:0]        centre,
    input  wire logic [SAMPLE_BITS-1:0]        below_one,
    input  wire logic [SAMPLE_BITS-1:0]        below_two,
    input  wire logic [icc_pkg::FIELD_W-1:0]   t_mag,
    input  wire logic [icc_pkg::SIX_T_W-1:0]   six_t,
    output logic                               comb_m0,
    output logic signed [2*SAMPLE_BITS+1:0]    prod
);
    import icc_pkg::*;

    localparam int DW = SAMPLE_BITS + 1;
    localparam int CW = ((DW > THR_W) ? DW : THR_W) + 1;
    localparam int SW = SAMPLE_BITS + 4;
    localparam int XW = ((SW > SIX_T_W) ? SW : SIX_T_W) + 1;

    logic [SAMPLE_BITS-1:0] a2, a1, b1, b2;
    logic                   edge_row;
    logic signed [DW-1:0]   d1, d2;
    logic signed [CW-1:0]   d1_x, d2_x, t_x, t_neg;
    logic                   diff_ok;
    logic signed [SW-1:0]   a2_s, a1_s, c_s, b1_s, b2_s, side_sum, sum;
    logic [SW-1:0]          sum_mag;

    // Mirror the neighbors that fall outside the frame
    always_comb
    begin
        a2       = above_two;
        a1       = above_one;
        b1       = below_one;
        b2       = below_two;
        edge_row = 1'b0;
        case (row_position)
            ROW_TOP:
            begin
                a1       = below_one;
                a2       = below_two;
                edge_row = 1'b1;
            end
            ROW_SECOND:
            begin
                a2 = below_two;
            end
            ROW_PENULT:
            begin
                b2 = above_two;
            end
            ROW_LAST:
            begin
                b1       = above_one;
                b2       = above_two;
                edge_row = 1'b1;
            end
            default:
            begin
                edge_row = 1'b0;   // interior and unused codes
            end
        endcase
    end

    assign d1 = $signed({1'b0, centre}) - $signed({1'b0, a1});
    assign d2 = $signed({1'b0, centre}) - $signed({1'b0, b1});

    assign d1_x  = {{(CW-DW){d1[DW-1]}}, d1};
    assign d2_x  = {{(CW-DW){d2[DW-1]}}, d2};
    assign t_x   = $signed({{(CW-FIELD_W){1'b0}}, t_mag});
    assign t_neg = -t_x;

    always_comb
    begin
        if (edge_row)
            diff_ok = (d1_x > t_x) || (d1_x < t_neg);
        else
            diff_ok = ((d1_x > t_x) && (d2_x > t_x)) || ((d1_x < t_neg) && (d2_x < t_neg));
    end

    // Five-tap comb sum: a2 + 4c + b2 - 3(a1 + b1)
    assign a2_s     = $signed({4'b0, a2});
    assign a1_s     = $signed({4'b0, a1});
    assign c_s      = $signed({4'b0, centre});
    assign b1_s     = $signed({4'b0, b1});
    assign b2_s     = $signed({4'b0, b2});
    assign side_sum = a1_s + b1_s;
    assign sum      = a2_s + (c_s <<< 2) + b2_s - side_sum - (side_sum <<< 1);
    assign sum_mag  = sum[SW-1] ? $unsigned(-sum) : $unsigned(sum);

    assign comb_m0 = diff_ok &&
                     ({{(XW-SW){1'b0}}, sum_mag} > {{(XW-SIX_T_W){1'b0}}, six_t});

    assign prod = d1 * d2;

endmodule

`default_nettype wire

// File: rtl/interlace_comb_check.sv
// Top level of the interlace comb check: stream ports, config registers and
// the three-stage item pipeline. Uses icc_pkg and icc_datapath.
`default_nettype none

// Usage
//   s_axis carries one pixel per item: row code, five vertical samples and the
//   motion-mask value. m_axis returns one mask value per item, in order.
//   A mask of 60 is demoted to 10 unless the pixel looks combed; any other
//   mask, or any mask while the threshold is negative, passes unchanged.
//   Config: cfg_we writes cfg_data to register cfg_index (0 threshold,
//   1 metric mode) at the clock edge; write only while no item is in flight.
//   The squared and scaled threshold settle in the cycle after a write.
//   Path: an accepted item passes through the input register, the product
//   register and the output register before it is shown on m_axis.
//   Throughput: one item per clock while m_axis_tready is high; the 17x17
//   difference product has a stage of its own ahead of the compare.
//   Stall: when m_axis_tready is low the stages fill up and s_axis_tready
//   drops once all three hold items; nothing is dropped or repeated.
//   Reset (rst_n low, asynchronous): pipeline emptied, threshold -1
//   (check off), metric mode 0.
module interlace_comb_check #(
    parameter int SAMPLE_BITS = icc_pkg::SAMPLE_BITS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Input items
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [2:0] row_position, [18:3] above_two, [34:19] above_one,
    // [50:35] centre, [66:51] below_one, [82:67] below_two,
    // [98:83] mask_in, [103:99] zero
    input  wire logic [icc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // Result items
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [15:0] mask_out
    output logic [icc_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    // Config write port
    input  wire logic                              cfg_we,
    input  wire logic [icc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [icc_pkg::THR_W-1:0]         cfg_data
);
    import icc_pkg::*;

    localparam int PW  = 2 * SAMPLE_BITS + 2;
    localparam int PCW = ((PW > T_SQ_W + 1) ? PW : T_SQ_W + 1) + 1;

    // Config registers and values derived from the threshold
    logic [THR_W-1:0]   thr_reg;
    logic               mode_reg;
    logic [SIX_T_W-1:0] six_t_reg, six_t_next;
    logic [T_SQ_W-1:0]  t_sq_reg, t_sq_next;
    logic [FIELD_W-1:0] t_mag;
    logic               check_on;

    // Stage 0: input register
    logic                   v0_reg;
    logic [ROW_W-1:0]       row_reg;
    logic [SAMPLE_BITS-1:0] a2_reg, a1_reg, c_reg, b1_reg, b2_reg;
    logic [FIELD_W-1:0]     mask0_reg;

    // Stage 1: product register
    logic                   v1_reg;
    logic [FIELD_W-1:0]     mask1_reg;
    logic                   pass1_reg, pass1_next;
    logic                   mode1_reg;
    logic                   comb1_reg;
    logic signed [PW-1:0]   prod1_reg;

    // Stage 2: output register
    logic                   v2_reg;
    logic [FIELD_W-1:0]     mask2_reg, mask2_next;

    logic                   rdy0, rdy1, rdy2;
    logic                   comb_m0;
    logic signed [PW-1:0]   prod;
    logic                   combed;

    assign t_mag    = thr_reg[FIELD_W-1:0];
    assign check_on = ~thr_reg[THR_W-1];

    // 6t and t*t for the non-negative threshold; ignored while the check is off
    assign six_t_next = {1'b0, t_mag, 2'b00} + {2'b00, t_mag, 1'b0};
    assign t_sq_next  = t_mag * t_mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= {THR_W{1'b1}};
            mode_reg  <= METRIC_COMB;
            six_t_reg <= '0;
            t_sq_reg  <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_THRESHOLD))
                thr_reg <= cfg_data;
            if (cfg_we && (cfg_index == REG_METRIC_MODE))
                mode_reg <= cfg_data[0];
            six_t_reg <= six_t_next;
            t_sq_reg  <= t_sq_next;
        end
    end

    // Ready runs back from the output; each stage moves when the next is free
    assign rdy2 = !v2_reg || m_axis_tready;
    assign rdy1 = !v1_reg || rdy2;
    assign rdy0 = !v0_reg || rdy1;
    assign s_axis_tready = rdy0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
                v0_reg <= s_axis_tvalid;
            if (rdy1)
                v1_reg <= v0_reg;
            if (rdy2)
                v2_reg <= v1_reg;
        end
    end

    // Stage 0 load: unpack the item, keeping the low SAMPLE_BITS of each sample
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && rdy0)
        begin
            row_reg   <= s_axis_tdata[2:0];
            a2_reg    <= s_axis_tdata[3  +: SAMPLE_BITS];
            a1_reg    <= s_axis_tdata[19 +: SAMPLE_BITS];
            c_reg     <= s_axis_tdata[35 +: SAMPLE_BITS];
            b1_reg    <= s_axis_tdata[51 +: SAMPLE_BITS];
            b2_reg    <= s_axis_tdata[67 +: SAMPLE_BITS];
            mask0_reg <= s_axis_tdata[98:83];
        end
    end

    icc_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .row_position (row_reg),
        .above_two    (a2_reg),
        .above_one    (a1_reg),
        .centre       (c_reg),
        .below_one    (b1_reg),
        .below_two    (b2_reg),
        .t_mag        (t_mag),
        .six_t        (six_t_reg),
        .comb_m0      (comb_m0),
        .prod         (prod)
    );

    // Mask goes through untouched unless it is "moving" and the check is on
    assign pass1_next = !check_on || (mask0_reg != MASK_MOVING);

    always_ff @(posedge clk)
    begin
        if (v0_reg && rdy1)
        begin
            mask1_reg <= mask0_reg;
            pass1_reg <= pass1_next;
            mode1_reg <= mode_reg;
            comb1_reg <= comb_m0;
            prod1_reg <= prod;
        end
    end

    // Stage 2: product compare and final mask choice
    always_comb
    begin
        if (mode1_reg == METRIC_PRODUCT)
            combed = $signed({{(PCW-PW){prod1_reg[PW-1]}}, prod1_reg})
                     > $signed({{(PCW-T_SQ_W){1'b0}}, t_sq_reg});
        else
            combed = comb1_reg;
        if (pass1_reg || combed)
            mask2_next = mask1_reg;
        else
            mask2_next = MASK_DEMOTED;
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg && rdy2)
            mask2_reg <= mask2_next;
    end

    assign m_axis_tvalid = v2_reg;
    assign m_axis_tdata  = mask2_reg;

endmodule

`default_nettype wire

// File: bench/comb_mask_checker.sv
// Mask checker for interlace_comb_check: watches both item channels and the
// config port, predicts each mask result and compares it in order. Uses icc_pkg.
module comb_mask_checker
    import icc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [THR_W-1:0]      cfg_data,
    output int                         mismatches,
    output int                         outstanding,
    output int                         masks_checked,
    output int                         demotions
);

    // Input item as packed on s_axis_tdata, row code in the low bits
    typedef struct packed {
        logic [FIELD_W-1:0] mask;
        logic [FIELD_W-1:0] below_two;
        logic [FIELD_W-1:0] below_one;
        logic [FIELD_W-1:0] centre;
        logic [FIELD_W-1:0] above_one;
        logic [FIELD_W-1:0] above_two;
        logic [ROW_W-1:0]   row;
    } pixel_t;

    logic signed [THR_W-1:0] thr_shadow;
    logic                    metric_shadow;
    logic [FIELD_W-1:0]      pending_masks[$];

    function automatic logic [FIELD_W-1:0] combed_mask(pixel_t px,
                                                        logic signed [THR_W-1:0] thr,
                                                        logic metric);
        longint a2, a1, c, b1, b2, t, d1, d2, comb_sum;
        bit     edge_row, diff_ok, combed;
        a2 = px.above_two;
        a1 = px.above_one;
        c  = px.centre;
        b1 = px.below_one;
        b2 = px.below_two;
        t  = thr;
        edge_row = 1'b0;
        if (t < 0 || px.mask != MASK_MOVING)
            return px.mask;
        // mirror the neighbours that fall outside the frame
        case (px.row)
            ROW_TOP:
            begin
                a1 = b1;
                a2 = b2;
                edge_row = 1'b1;
            end
            ROW_SECOND:
                a2 = b2;
            ROW_PENULT:
                b2 = a2;
            ROW_LAST:
            begin
                b1 = a1;
                b2 = a2;
                edge_row = 1'b1;
            end
            default:;
        endcase
        d1 = c - a1;
        d2 = c - b1;
        if (metric == METRIC_COMB)
        begin
            if (edge_row)
                diff_ok = (d1 > t) || (d1 < -t);
            else
                diff_ok = (d1 > t && d2 > t) || (d1 < -t && d2 < -t);
            comb_sum = a2 + 4 * c + b2 - 3 * (a1 + b1);
            if (comb_sum < 0)
                comb_sum = -comb_sum;
            combed = diff_ok && (comb_sum > 6 * t);
        end
        else
            combed = (d1 * d2) > (t * t);
        return combed ? px.mask : MASK_DEMOTED;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t             px;
        logic [FIELD_W-1:0] want;
        if (!rst_n)
        begin
            thr_shadow    = '1;
            metric_shadow = METRIC_COMB;
            pending_masks.delete();
            mismatches    = 0;
            outstanding   = 0;
            masks_checked = 0;
            demotions     = 0;
        end
        else
        begin
            // results first, so an item accepted this edge cannot cover a stray result
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_masks.size() == 0)
                begin
                    $display("%0t: mask_out %h arrived with no item pending",
                             $time, m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = pending_masks.pop_front();
                    masks_checked++;
                    if (m_axis_tdata !== want)
                    begin
                        $display("%0t: mask_out mismatch, expected %h, got %h",
                                 $time, want, m_axis_tdata);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                px   = pixel_t'(s_axis_tdata[$bits(pixel_t)-1:0]);
                want = combed_mask(px, thr_shadow, metric_shadow);
                if (px.mask == MASK_MOVING && want == MASK_DEMOTED)
                    demotions++;
                pending_masks.push_back(want);
            end
            // register writes take effect for items after this edge
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_THRESHOLD:   thr_shadow    = cfg_data;
                    REG_METRIC_MODE: metric_shadow = cfg_data[0];
                    default:;
                endcase
            end
            outstanding = pending_masks.size();
        end
    end

endmodule

// File: bench/tb.sv
// Testbench top for interlace_comb_check: clock, reset, config writes and
// pixel stimulus with random idling. Uses icc_pkg and comb_mask_checker.
module tb;
    import icc_pkg::*;

    // no item moving for this many cycles ends the run
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_PHASES  = 13;
    localparam int PHASE_ITEMS    = 125;
    // input, product and output register
    localparam int PIPE_DEPTH     = 3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_THRESHOLD;
    logic [THR_W-1:0]      cfg_data = '0;

    int mismatches;
    int outstanding;
    int masks_checked;
    int demotions;

    int items_sent = 0;
    int reg_writes = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    // when set, that side never idles (stretches of full-rate traffic)
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    interlace_comb_check uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    comb_mask_checker u_mask_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .masks_checked (masks_checked),
        .demotions     (demotions)
    );

    // Idle lengths: mostly none, some short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [FIELD_W-1:0] clamp_sample(longint v);
        if (v < 0)
            return '0;
        if (v > 65535)
            return '1;
        return v[FIELD_W-1:0];
    endfunction

    // Result side: tready drops for random stalls unless rx_steady is set
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!rx_steady)
                stall_left = gap_len();
        end
    end

    // Watchdog: any handshake on either channel resets the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog, no item moved for %0d cycles, %0d results pending",
                         $time, idle_cycles, outstanding);
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // Hold off the sender until every expected mask has come back
    task automatic wait_for_drain();
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // Registers are only written with the pipeline empty; afterwards the task
    // waits for the derived threshold terms to settle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] value);
        wait_for_drain();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        repeat (2) @(negedge clk);
        reg_writes++;
    endtask

    // One pixel item; called and returns at a falling edge
    task automatic send_pixel(logic [ROW_W-1:0] row, logic [FIELD_W-1:0] a2,
                              logic [FIELD_W-1:0] a1, logic [FIELD_W-1:0] c,
                              logic [FIELD_W-1:0] b1, logic [FIELD_W-1:0] b2,
                              logic [FIELD_W-1:0] mask);
        int gap;
        gap = tx_steady ? 0 : gap_len();
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  = {5'b0, mask, b2, b1, c, a1, a2, row};
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        items_sent++;
    endtask

    // Random pixel; many items are near-threshold comb patterns around a
    // random base level, so both verdicts of each test come up often.
    task automatic random_pixel(longint thr_val);
        longint             base, span, offset, sgn1, sgn2;
        logic [FIELD_W-1:0] a2, a1, c, b1, b2, mask;
        logic [ROW_W-1:0]   row;
        int                 kind;
        row  = ROW_W'($urandom_range(0, 7));
        kind = $urandom_range(0, 9);
        base = longint'($urandom_range(0, 65535));
        span = (thr_val < 0) ? longint'($urandom_range(0, 2000)) : thr_val;
        offset = span + longint'($urandom_range(0, 8)) - 4;
        sgn1 = $urandom_range(0, 1) ? 1 : -1;
        // mostly same-sign differences, sometimes opposite
        sgn2 = ($urandom_range(0, 3) == 0) ? -sgn1 : sgn1;
        case (kind)
            0, 1, 2:
            begin
                a2 = FIELD_W'($urandom);
                a1 = FIELD_W'($urandom);
                c  = FIELD_W'($urandom);
                b1 = FIELD_W'($urandom);
                b2 = FIELD_W'($urandom);
            end
            3, 4, 5, 6:
            begin
                c  = clamp_sample(base);
                a1 = clamp_sample(base - sgn1 * offset);
                b1 = clamp_sample(base - sgn2 * (offset + longint'($urandom_range(0, 16))));
                a2 = clamp_sample(base - sgn1 * longint'($urandom_range(0, int'(span))));
                b2 = clamp_sample(base - sgn2 * longint'($urandom_range(0, int'(span))));
            end
            7, 8:
            begin
                c  = clamp_sample(base);
                a1 = clamp_sample(base + longint'($urandom_range(0, 6)) - 3);
                b1 = clamp_sample(base + longint'($urandom_range(0, 6)) - 3);
                a2 = clamp_sample(base + longint'($urandom_range(0, 6)) - 3);
                b2 = clamp_sample(base + longint'($urandom_range(0, 6)) - 3);
            end
            default:
            begin
                a2 = $urandom_range(0, 1) ? '1 : '0;
                a1 = $urandom_range(0, 1) ? '1 : '0;
                c  = $urandom_range(0, 1) ? '1 : '0;
                b1 = $urandom_range(0, 1) ? '1 : '0;
                b2 = $urandom_range(0, 1) ? '1 : '0;
            end
        endcase
        case ($urandom_range(0, 9))
            0:       mask = MASK_DEMOTED;
            1:       mask = FIELD_W'($urandom);
            2:       mask = $urandom_range(0, 1) ? '1 : '0;
            default: mask = MASK_MOVING;
        endcase
        send_pixel(row, a2, a1, c, b1, b2, mask);
    endtask

    initial
    begin
        logic signed [THR_W-1:0] thr;
        logic                    metric;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // --- directed part ---
        // reset threshold is negative: a moving mask passes even when flat
        send_pixel(ROW_INTERIOR, 16'd7, 16'd7, 16'd7, 16'd7, 16'd7, MASK_MOVING);

        // threshold 0, five-tap test: strong comb on every row code,
        // the unused codes included
        write_reg(REG_THRESHOLD, '0);
        write_reg(REG_METRIC_MODE, {16'h0, METRIC_COMB});
        for (int r = 0; r < 8; r++)
            send_pixel(ROW_W'(r), 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, MASK_MOVING);
        // top row: above_one is junk and must be replaced by below_one
        send_pixel(ROW_TOP, 16'hFFFF, 16'hFFFF, 16'd100, 16'd0, 16'd0, MASK_MOVING);
        // last row: below samples are junk, only the difference above counts
        send_pixel(ROW_LAST, 16'd0, 16'd0, 16'd100, 16'hFFFF, 16'hFFFF, MASK_MOVING);
        // flat column at zero threshold is not combed
        send_pixel(ROW_INTERIOR, 16'd5, 16'd5, 16'd5, 16'd5, 16'd5, MASK_MOVING);
        // masks other than moving go straight through
        send_pixel(ROW_INTERIOR, 16'd5, 16'd5, 16'd5, 16'd5, 16'd5, 16'hFFFF);
        send_pixel(ROW_INTERIOR, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0);

        // largest threshold: even a full-scale step does not exceed it
        write_reg(REG_THRESHOLD, 17'd65535);
        send_pixel(ROW_INTERIOR, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, MASK_MOVING);

        // product test at threshold 100
        write_reg(REG_THRESHOLD, 17'd100);
        write_reg(REG_METRIC_MODE, {16'h0, METRIC_PRODUCT});
        // differences of opposite sign give a negative product
        send_pixel(ROW_INTERIOR, 16'd0, 16'd0, 16'd500, 16'd1000, 16'd0, MASK_MOVING);
        // second row behaves as interior here
        send_pixel(ROW_SECOND, 16'hFFFF, 16'd0, 16'd500, 16'd0, 16'd0, MASK_MOVING);
        // top row: squared difference equal to t*t is not enough
        send_pixel(ROW_TOP, 16'd0, 16'hFFFF, 16'd200, 16'd100, 16'd0, MASK_MOVING);
        // last row: squared difference just above t*t
        send_pixel(ROW_LAST, 16'd0, 16'd0, 16'd101, 16'hFFFF, 16'd0, MASK_MOVING);

        // --- random part ---
        // the first phases pin the register extremes, later ones draw them
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    thr    = '0;
                    metric = METRIC_COMB;
                end
                1:
                begin
                    thr    = 17'sd65535;
                    metric = METRIC_PRODUCT;
                end
                2:
                begin
                    // most negative value: check off
                    thr    = 17'h10000;
                    metric = METRIC_COMB;
                end
                default:
                begin
                    case ($urandom_range(0, 6))
                        0:       thr = '1;
                        1:       thr = '0;
                        2:       thr = 17'sd65535;
                        3:       thr = THR_W'($urandom);
                        4:       thr = THR_W'($urandom_range(1, 300));
                        5:       thr = THR_W'($urandom_range(0, 65535));
                        default: thr = THR_W'($urandom_range(0, 3000));
                    endcase
                    metric = 1'($urandom_range(0, 1));
                end
            endcase
            write_reg(REG_THRESHOLD, thr);
            // upper bits of the mode write are don't-care; exercise them
            write_reg(REG_METRIC_MODE, {16'($urandom), metric});
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // now and then let the pipeline run dry mid-phase
                if ($urandom_range(0, 99) == 0)
                    wait_for_drain();
                random_pixel(longint'(thr));
            end
        end

        // --- wind down ---
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        wait_for_drain();
        repeat (PIPE_DEPTH + 4) @(negedge clk);

        $display("tb: %0d pixel items sent, %0d register writes across both metrics",
                 items_sent, reg_writes);
        $display("tb: %0d masks checked, %0d moving masks demoted, %0d mismatches",
                 masks_checked, demotions, mismatches);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
